// ===== sv/icp_pkg.sv =====
package icp_pkg;

  localparam int SQRT_STAGES = 16;
  localparam int SQRT_STEPS  = 32 / SQRT_STAGES;
  localparam int DIV_STAGES  = 16;
  localparam int DIV_STEPS   = 32 / DIV_STAGES;
  // abs, normalize, square, sum, root, numerator, divide, sign
  localparam int UNIT_LAT    = SQRT_STAGES + DIV_STAGES + 6;
  localparam int TAIL_LAT    = 5;

  localparam int WIDTH_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 20'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_0,
    CFG_WIDTH_1,
    CFG_WIDTH_2,
    CFG_WIDTH_3
  } cfg_reg_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] pair);
    logic [35:0] t;
    logic [35:0] trial;
    sqrt_st_t    r;
    t     = {s.rem[33:0], pair};
    trial = {2'b00, s.root, 2'b01};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_st_t div_step(input div_st_t s, input logic [31:0] den,
                                       input logic nbit);
    logic [32:0] t;
    div_st_t     r;
    t = {s.rem, nbit};
    if (t >= {1'b0, den}) begin
      r.rem = 32'(t - {1'b0, den});
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  // left shift that brings the larger component to at least 2^30
  function automatic logic [4:0] norm_shift(input logic [31:0] m);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) pos = 5'(i);
    end
    return (pos >= 5'd30) ? 5'd0 : 5'(5'd30 - pos);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7fff_ffff;
    else if (v < -34'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ===== sv/intersection_corner_points.sv =====
// Channel  | Signals                                         | Handshake
// request  | start, center_*, major_*, minor_*, *_road_type  | start && !busy
// result   | done, corner1..4_x/y, degenerate                | done, one cycle
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid && cfg_ready
//
// One request per cycle; a result passes the 16-stage root and 16-stage divide
// pipelines and then the tail stages A to E.
// busy stays low; the receiver cannot stall, so nothing in the pipe ever holds.
// Synchronous reset clears the valid bits and restores all half-widths to 1.0.
module intersection_corner_points (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            center_x,
  input  logic signed [31:0]            center_y,
  input  logic signed [31:0]            major_dir_x,
  input  logic signed [31:0]            major_dir_y,
  input  logic signed [31:0]            minor_dir_x,
  input  logic signed [31:0]            minor_dir_y,
  input  logic [1:0]                    major_road_type,
  input  logic [1:0]                    minor_road_type,
  output logic                          done,
  output logic signed [31:0]            corner1_x,
  output logic signed [31:0]            corner1_y,
  output logic signed [31:0]            corner2_x,
  output logic signed [31:0]            corner2_y,
  output logic signed [31:0]            corner3_x,
  output logic signed [31:0]            corner3_y,
  output logic signed [31:0]            corner4_x,
  output logic signed [31:0]            corner4_y,
  output logic                          degenerate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [icp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [icp_pkg::WIDTH_W-1:0]   cfg_data
);
  import icp_pkg::*;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [1:0]         maj_type;
    logic [1:0]         min_type;
  } side_t;

  logic [WIDTH_W-1:0] width0, width1, width2, width3;

  side_t side_d [UNIT_LAT];
  logic  vld_d  [UNIT_LAT];

  logic signed [31:0] jx, jy, nx, ny;
  logic               okj, okn;

  // stage A
  logic               a_vld, a_deg;
  side_t              a_side;
  logic signed [31:0] a_jx, a_jy, a_nx, a_ny;
  logic signed [63:0] a_pj, a_pn;
  // stage B
  logic               b_vld, b_deg;
  side_t              b_side;
  logic [30:0]        b_mag [4];
  logic               b_neg [4];
  // stage C
  logic               c_vld, c_deg;
  side_t              c_side;
  logic [50:0]        c_prod [4];
  logic               c_neg [4];
  // stage D
  logic               d_vld, d_deg;
  side_t              d_side;
  logic signed [21:0] d_off [4];

  logic signed [31:0] nx_f, ny_f;
  logic               flip;
  logic [WIDTH_W-1:0] wmaj, wmin;
  logic [20:0]        rnd [4];
  logic signed [33:0] cx_e, cy_e, ax_e, ay_e, bx_e, by_e;

  function automatic logic [WIDTH_W-1:0] pick_width(
    input logic [1:0] t, input logic [WIDTH_W-1:0] w0, input logic [WIDTH_W-1:0] w1,
    input logic [WIDTH_W-1:0] w2, input logic [WIDTH_W-1:0] w3);
    logic [WIDTH_W-1:0] w;
    unique case (cfg_reg_t'(t))
      CFG_WIDTH_0: w = w0;
      CFG_WIDTH_1: w = w1;
      CFG_WIDTH_2: w = w2;
      CFG_WIDTH_3: w = w3;
      default:     w = w0;
    endcase
    return w;
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    return v[31] ? 31'(-v) : v[30:0];
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width0 <= WIDTH_RESET;
      width1 <= WIDTH_RESET;
      width2 <= WIDTH_RESET;
      width3 <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH_0: width0 <= cfg_data;
        CFG_WIDTH_1: width1 <= cfg_data;
        CFG_WIDTH_2: width2 <= cfg_data;
        CFG_WIDTH_3: width3 <= cfg_data;
        default:     width0 <= width0;
      endcase
    end
  end

  icp_unit u_major (
    .clk (clk),
    .dx  (major_dir_x),
    .dy  (major_dir_y),
    .ux  (jx),
    .uy  (jy),
    .ok  (okj)
  );

  icp_unit u_minor (
    .clk (clk),
    .dx  (minor_dir_x),
    .dy  (minor_dir_y),
    .ux  (nx),
    .uy  (ny),
    .ok  (okn)
  );

  // valid bits and side data ride alongside the unit-vector pipes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < UNIT_LAT; i++) vld_d[i] <= 1'b0;
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_d[0] <= start && !busy;
      for (int i = 1; i < UNIT_LAT; i++) vld_d[i] <= vld_d[i-1];
      a_vld <= vld_d[UNIT_LAT-1];
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      done  <= d_vld;
    end
  end

  always_comb begin
    flip = a_pj < a_pn;
    nx_f = flip ? -a_nx : a_nx;
    ny_f = flip ? -a_ny : a_ny;
    wmaj = pick_width(b_side.maj_type, width0, width1, width2, width3);
    wmin = pick_width(b_side.min_type, width0, width1, width2, width3);
    for (int i = 0; i < 4; i++) begin
      rnd[i] = 21'((c_prod[i] + (51'd1 << 29)) >> 30);
    end
    cx_e = 34'(d_side.cx);
    cy_e = 34'(d_side.cy);
    ax_e = 34'(d_off[0]);
    ay_e = 34'(d_off[1]);
    bx_e = 34'(d_off[2]);
    by_e = 34'(d_off[3]);
  end

  always_ff @(posedge clk) begin
    side_d[0] <= '{cx: center_x, cy: center_y,
                   maj_type: major_road_type, min_type: minor_road_type};
    for (int i = 1; i < UNIT_LAT; i++) side_d[i] <= side_d[i-1];

    // A: cross product of the unit vectors
    a_side <= side_d[UNIT_LAT-1];
    a_deg  <= !(okj && okn);
    a_jx   <= jx;
    a_jy   <= jy;
    a_nx   <= nx;
    a_ny   <= ny;
    a_pj   <= 64'(jx) * 64'(ny);
    a_pn   <= 64'(jy) * 64'(nx);

    // B: flip minor, split into magnitude and sign
    b_side   <= a_side;
    b_deg    <= a_deg;
    b_mag[0] <= mag31(nx_f);
    b_mag[1] <= mag31(ny_f);
    b_mag[2] <= mag31(a_jx);
    b_mag[3] <= mag31(a_jy);
    b_neg[0] <= nx_f[31];
    b_neg[1] <= ny_f[31];
    b_neg[2] <= a_jx[31];
    b_neg[3] <= a_jy[31];

    // C: scale by half-widths
    c_side    <= b_side;
    c_deg     <= b_deg;
    c_prod[0] <= 51'(wmaj) * 51'(b_mag[0]);
    c_prod[1] <= 51'(wmaj) * 51'(b_mag[1]);
    c_prod[2] <= 51'(wmin) * 51'(b_mag[2]);
    c_prod[3] <= 51'(wmin) * 51'(b_mag[3]);
    for (int i = 0; i < 4; i++) c_neg[i] <= b_neg[i];

    // D: round magnitude, restore sign
    d_side <= c_side;
    d_deg  <= c_deg;
    for (int i = 0; i < 4; i++) begin
      d_off[i] <= c_neg[i] ? -$signed({1'b0, rnd[i]}) : $signed({1'b0, rnd[i]});
    end

    // E: corners, saturated
    corner1_x  <= sat32(cx_e - ax_e - bx_e);
    corner1_y  <= sat32(cy_e - ay_e - by_e);
    corner2_x  <= sat32(cx_e - ax_e + bx_e);
    corner2_y  <= sat32(cy_e - ay_e + by_e);
    corner3_x  <= sat32(cx_e + ax_e - bx_e);
    corner3_y  <= sat32(cy_e + ay_e - by_e);
    corner4_x  <= sat32(cx_e + ax_e + bx_e);
    corner4_y  <= sat32(cy_e + ay_e + by_e);
    degenerate <= d_deg;
  end

endmodule

// ===== sv/icp_sqrt.sv =====
module icp_sqrt (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import icp_pkg::*;

  sqrt_st_t    st_q  [SQRT_STAGES];
  logic [63:0] rad_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_st_t    cur;
    logic [63:0] cur_rad;
    sqrt_st_t    nxt;

    if (s == 0) begin : g_first
      assign cur     = '0;
      assign cur_rad = radicand;
    end else begin : g_rest
      assign cur     = st_q[s-1];
      assign cur_rad = rad_q[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        nxt = sqrt_step(nxt, cur_rad[63-2*k -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      st_q[s]  <= nxt;
      rad_q[s] <= cur_rad << (2 * SQRT_STEPS);
    end
  end

  assign root = st_q[SQRT_STAGES-1].root;

endmodule

// ===== sv/icp_div.sv =====
module icp_div (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import icp_pkg::*;

  div_st_t     st_q  [DIV_STAGES];
  logic [31:0] low_q [DIV_STAGES];
  logic [31:0] den_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_st_t     cur;
    logic [31:0] cur_low;
    logic [31:0] cur_den;
    div_st_t     nxt;

    if (s == 0) begin : g_first
      assign cur     = '{rem: num[63:32], quo: '0};
      assign cur_low = num[31:0];
      assign cur_den = den;
    end else begin : g_rest
      assign cur     = st_q[s-1];
      assign cur_low = low_q[s-1];
      assign cur_den = den_q[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < DIV_STEPS; k++) begin
        nxt = div_step(nxt, cur_den, cur_low[31-k]);
      end
    end

    always_ff @(posedge clk) begin
      st_q[s]  <= nxt;
      low_q[s] <= cur_low << DIV_STEPS;
      den_q[s] <= cur_den;
    end
  end

  assign quo = st_q[DIV_STAGES-1].quo;

endmodule

// ===== sv/icp_unit.sv =====
module icp_unit (
  input  logic               clk,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy,
  output logic               ok
);
  import icp_pkg::*;

  localparam int AX_DLY  = SQRT_STAGES + 2;
  localparam int SGN_DLY = UNIT_LAT - 2;

  logic [31:0] ax0, ay0;
  logic        sx0, sy0, nz0;
  logic [31:0] ax1, ay1;
  logic [63:0] sqx, sqy;
  logic [63:0] nsum;
  logic [31:0] len;
  logic [63:0] numx, numy;
  logic [31:0] den;
  logic [31:0] qx, qy;
  logic [31:0] m0;

  logic [31:0] axd [AX_DLY];
  logic [31:0] ayd [AX_DLY];
  logic [2:0]  sgd [SGN_DLY];

  assign m0 = (ax0 > ay0) ? ax0 : ay0;

  always_ff @(posedge clk) begin
    ax0 <= dx[31] ? 32'(-dx) : 32'(dx);
    ay0 <= dy[31] ? 32'(-dy) : 32'(dy);
    sx0 <= dx[31];
    sy0 <= dy[31];
    nz0 <= (dx != '0) || (dy != '0);

    ax1 <= ax0 << norm_shift(m0);
    ay1 <= ay0 << norm_shift(m0);

    sqx <= 64'(ax1) * 64'(ax1);
    sqy <= 64'(ay1) * 64'(ay1);
    nsum <= sqx + sqy;

    axd[0] <= ax1;
    ayd[0] <= ay1;
    for (int i = 1; i < AX_DLY; i++) begin
      axd[i] <= axd[i-1];
      ayd[i] <= ayd[i-1];
    end
    sgd[0] <= {sx0, sy0, nz0};
    for (int i = 1; i < SGN_DLY; i++) begin
      sgd[i] <= sgd[i-1];
    end

    // rounding half up: add half the divisor
    numx <= (64'(axd[AX_DLY-1]) << 30) + 64'(len >> 1);
    numy <= (64'(ayd[AX_DLY-1]) << 30) + 64'(len >> 1);
    den  <= len;

    ok <= sgd[SGN_DLY-1][0];
    ux <= !sgd[SGN_DLY-1][0] ? '0 : (sgd[SGN_DLY-1][2] ? -$signed(qx) : $signed(qx));
    uy <= !sgd[SGN_DLY-1][0] ? '0 : (sgd[SGN_DLY-1][1] ? -$signed(qy) : $signed(qy));
  end

  icp_sqrt u_sqrt (
    .clk      (clk),
    .radicand (nsum),
    .root     (len)
  );

  icp_div u_div_x (
    .clk (clk),
    .num (numx),
    .den (den),
    .quo (qx)
  );

  icp_div u_div_y (
    .clk (clk),
    .num (numy),
    .den (den),
    .quo (qy)
  );

endmodule
